>>> hw/rtl/ftc_pkg.sv
// Flow table traffic counter: shared types and constants.
// No dependencies; used by the interfaces, the modules and the checker.
`default_nettype none

package ftc_pkg;

	// Result status codes
	localparam logic [1:0] ST_EXISTING = 2'd0;
	localparam logic [1:0] ST_CREATED  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	// Five-tuple key as held in the table
	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] l4_src;
		logic [15:0] l4_dst;
		logic [7:0]  proto;
	} key_t;

	// Per-flow counters
	typedef struct packed {
		logic [63:0] rx_octets;
		logic [63:0] rx_pkts;
		logic [63:0] tx_octets;
		logic [63:0] tx_pkts;
	} cnt_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic scan;
		logic resolve;
		logic cnt_rd;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hit;
		logic scan_end;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ftc_ifs.sv
// Flow table traffic counter: packet record and result channel interfaces.
// Depends on ftc_pkg.
`default_nettype none

interface ftc_pkt_if import ftc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] source_address;
	logic [31:0] destination_address;
	logic [15:0] source_port;
	logic [15:0] destination_port;
	logic [7:0]  protocol_number;
	logic        is_inbound;
	logic [31:0] byte_count;

	modport source (output valid, source_address, destination_address, source_port,
		destination_port, protocol_number, is_inbound, byte_count, input ready);
	modport sink (input valid, source_address, destination_address, source_port,
		destination_port, protocol_number, is_inbound, byte_count, output ready);
endinterface

interface ftc_res_if import ftc_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  slot;
	logic [63:0] flow_rx_bytes;
	logic [63:0] flow_rx_packets;
	logic [63:0] flow_tx_bytes;
	logic [63:0] flow_tx_packets;
	logic [63:0] sum_rx_bytes;
	logic [63:0] sum_rx_packets;
	logic [63:0] sum_tx_bytes;
	logic [63:0] sum_tx_packets;

	modport source (output valid, status, slot, flow_rx_bytes, flow_rx_packets,
		flow_tx_bytes, flow_tx_packets, sum_rx_bytes, sum_rx_packets, sum_tx_bytes,
		sum_tx_packets, input ready);
	modport sink (input valid, status, slot, flow_rx_bytes, flow_rx_packets,
		flow_tx_bytes, flow_tx_packets, sum_rx_bytes, sum_rx_packets, sum_tx_bytes,
		sum_tx_packets, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ftc_ctrl.sv
// Flow table traffic counter: sequencing state machine.
// Depends on ftc_pkg; drives ftc_datapath through cmd_t, reads sts_t.
`default_nettype none

module ftc_ctrl import ftc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pkt_valid,
	output logic      pkt_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_READ   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		pkt_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				pkt_ready = 1'b1;
				if (pkt_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit || sts.scan_end) begin
					cmd.resolve = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ftc_datapath.sv
// Flow table traffic counter: key and counter memories, scan, totals, result register.
// Depends on ftc_pkg and the channel interfaces; commanded by ftc_ctrl.
`default_nettype none

module ftc_datapath import ftc_pkg::*; #(
	parameter int FLOW_SLOTS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ftc_pkt_if.sink   pkt,
	ftc_res_if.source res,
	input  wire cmd_t cmd,
	output sts_t      sts
);

	localparam int AW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
	localparam int CW = $clog2(FLOW_SLOTS + 1);

	key_t            kmem [FLOW_SLOTS];
	cnt_t            cmem [FLOW_SLOTS];

	key_t            key_q;
	logic            inbound_q;
	logic [31:0]     bytes_q;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   idx_q;
	logic            chk_q;
	logic [AW-1:0]   chk_idx_q;
	key_t            key_rd_s1;
	cnt_t            cnt_rd_s1;
	logic [AW-1:0]   slot_q;
	logic            new_q;
	logic            full_q;
	cnt_t            tot_q;
	logic            res_valid_q;
	logic [1:0]      status_q;
	logic [5:0]      slot_out_q;
	cnt_t            flow_out_q;

	logic            issue;
	logic            hit;
	cnt_t            base;
	cnt_t            upd;
	cnt_t            tot_upd;
	logic [15:0]     slot_ext;
	logic [63:0]     bytes64;

	assign issue   = cmd.scan && (idx_q < fill_q);
	assign hit     = chk_q && (key_rd_s1 == key_q);
	assign bytes64 = 64'(bytes_q);

	assign sts.hit      = hit;
	assign sts.scan_end = !chk_q && !(idx_q < fill_q);
	assign sts.out_free = !res_valid_q || res.ready;

	// Captured packet record
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q.src_addr <= pkt.source_address;
			key_q.dst_addr <= pkt.destination_address;
			key_q.l4_src   <= pkt.source_port;
			key_q.l4_dst   <= pkt.destination_port;
			key_q.proto    <= pkt.protocol_number;
			inbound_q      <= pkt.is_inbound;
			bytes_q        <= pkt.byte_count;
		end
	end

	// Scan pointer and compare stage; only slots below the fill count are live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			chk_q <= 1'b0;
		end else if (cmd.capture) begin
			idx_q <= '0;
			chk_q <= 1'b0;
		end else if (cmd.scan) begin
			chk_q <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chk_idx_q <= idx_q[AW-1:0];
		end
	end

	// Key memory
	always_ff @(posedge clk) begin
		if (issue) begin
			key_rd_s1 <= kmem[idx_q[AW-1:0]];
		end
		if (cmd.commit && new_q && !full_q) begin
			kmem[slot_q] <= key_q;
		end
	end

	// Lookup outcome
	always_ff @(posedge clk) begin
		if (cmd.resolve) begin
			slot_q <= hit ? chk_idx_q : fill_q[AW-1:0];
			new_q  <= !hit;
			full_q <= !hit && (fill_q == CW'(FLOW_SLOTS));
		end
	end

	// Counter memory
	always_ff @(posedge clk) begin
		if (cmd.cnt_rd) begin
			cnt_rd_s1 <= cmem[slot_q];
		end
		if (cmd.commit && !full_q) begin
			cmem[slot_q] <= upd;
		end
	end

	// Counter update; a new slot starts from zero
	always_comb begin
		base    = new_q ? '0 : cnt_rd_s1;
		upd     = base;
		tot_upd = tot_q;
		if (inbound_q) begin
			upd.rx_octets     = base.rx_octets + bytes64;
			upd.rx_pkts       = base.rx_pkts + 64'd1;
			tot_upd.rx_octets = tot_q.rx_octets + bytes64;
			tot_upd.rx_pkts   = tot_q.rx_pkts + 64'd1;
		end else begin
			upd.tx_octets     = base.tx_octets + bytes64;
			upd.tx_pkts       = base.tx_pkts + 64'd1;
			tot_upd.tx_octets = tot_q.tx_octets + bytes64;
			tot_upd.tx_pkts   = tot_q.tx_pkts + 64'd1;
		end
	end

	assign slot_ext = 16'(slot_q);

	// Fill count and global totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			tot_q  <= '0;
		end else if (cmd.commit && !full_q) begin
			tot_q <= tot_upd;
			if (new_q) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (full_q) begin
				status_q   <= ST_FULL;
				slot_out_q <= '0;
				flow_out_q <= '0;
			end else begin
				status_q   <= new_q ? ST_CREATED : ST_EXISTING;
				slot_out_q <= slot_ext[5:0];
				flow_out_q <= upd;
			end
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = status_q;
	assign res.slot            = slot_out_q;
	assign res.flow_rx_bytes   = flow_out_q.rx_octets;
	assign res.flow_rx_packets = flow_out_q.rx_pkts;
	assign res.flow_tx_bytes   = flow_out_q.tx_octets;
	assign res.flow_tx_packets = flow_out_q.tx_pkts;
	assign res.sum_rx_bytes    = tot_q.rx_octets;
	assign res.sum_rx_packets  = tot_q.rx_pkts;
	assign res.sum_tx_bytes    = tot_q.tx_octets;
	assign res.sum_tx_packets  = tot_q.tx_pkts;

endmodule

`default_nettype wire

>>> hw/rtl/flow_table_traffic_counter.sv
// Flow table traffic counter: top level joining controller and datapath.
// Depends on ftc_pkg, ftc_ifs, ftc_ctrl and ftc_datapath.
//
// Usage:
//   pkt carries one packet record per item (five-tuple, direction, byte count).
//   res carries one result item per packet: status, slot, the flow's counters
//   after the update and the global totals.
//   Lookup walks the occupied slots one per cycle through the key memory port,
//   stopping at the first match. The result is written after the scan, the
//   counter read and the commit step, so its wait grows with the matching slot
//   on a hit and with the occupied slots on a miss. One item is in work at a
//   time; the next item is accepted the cycle after the result is written.
//   The result register holds a finished item while the next one is taken in
//   and searched; a stalled receiver only holds the update step.
//   Reset empties the table (fill count to zero) and clears the totals; no
//   clearing pass is needed, the block is ready right after reset.
//   Sum fields read the totals register, which the next item does not change
//   before the held result is taken.
`default_nettype none

module flow_table_traffic_counter import ftc_pkg::*; #(
	parameter int FLOW_SLOTS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ftc_pkt_if.sink   pkt,
	ftc_res_if.source res
);

	cmd_t cmd;
	sts_t sts;

	ftc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ftc_datapath #(
		.FLOW_SLOTS (FLOW_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.res    (res),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

`default_nettype wire

>>> hw/rtl/ftc_checker.sv
// Flow table traffic counter: port-level checker and its bind.
// Depends on ftc_pkg; attaches to flow_table_traffic_counter.
`default_nettype none

module ftc_checker import ftc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  status,
	input wire logic [5:0]  slot,
	input wire logic [63:0] flow_rx_packets,
	input wire logic [63:0] flow_tx_packets,
	input wire logic [63:0] flow_rx_bytes
);

	// A result waits until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// Only defined status codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == ST_EXISTING || status == ST_CREATED || status == ST_FULL))
		else $error("bad status code");

	// Full table reports slot zero and zero flow fields, tx byte count apart
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |->
			slot == 6'd0 && flow_rx_bytes == 64'd0 && flow_rx_packets == 64'd0
			&& flow_tx_packets == 64'd0)
		else $error("full result carries flow data");

	// A new flow has seen exactly this one packet
	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_CREATED |->
			(flow_rx_packets + flow_tx_packets) == 64'd1)
		else $error("new flow counters wrong");

endmodule

bind flow_table_traffic_counter ftc_checker u_ftc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.status          (res.status),
	.slot            (res.slot),
	.flow_rx_packets (res.flow_rx_packets),
	.flow_tx_packets (res.flow_tx_packets),
	.flow_rx_bytes   (res.flow_rx_bytes)
);

`default_nettype wire
